/* sv/sbt_pkg.sv */
// Shared types, constants and character-class functions for the source byte tokenizer.
package sbt_pkg;

  // Offset and length width, and the saturation point of both
  localparam int unsigned OFFSET_BITS = 24;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  // Result queue geometry
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  // Token kinds
  localparam logic [5:0] KIND_EOF         = 6'd0;
  localparam logic [5:0] KIND_ERROR       = 6'd1;
  localparam logic [5:0] KIND_IDENT       = 6'd2;
  localparam logic [5:0] KIND_NUMBER      = 6'd3;
  localparam logic [5:0] KIND_STRING      = 6'd4;
  localparam logic [5:0] KIND_SINGLE_BASE = 6'd5;
  localparam logic [5:0] KIND_OPER_BASE   = 6'd16;
  localparam logic [5:0] KIND_MAX         = 6'd37;

  // Error codes
  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_UNRECOGNISED = 2'd1;
  localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

  // Characters with a special role
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Number of operators that may take a second byte
  localparam logic [3:0] OPER_COUNT = 4'd11;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_OPER
  } mode_e;

  typedef struct packed {
    logic [5:0]             kind;
    logic [OFFSET_BITS-1:0] offset;
    logic [OFFSET_BITS-1:0] length;
    logic [1:0]             err;
    logic                   last;
  } tok_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } lookup_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic is_decimal(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  // One-character tokens: ; ? % . , ( ) { } [ ]
  function automatic lookup_t single_lookup(input logic [7:0] c);
    lookup_t r;
    r.hit = 1'b1;
    case (c)
      ";":     r.idx = 4'd0;
      "?":     r.idx = 4'd1;
      "%":     r.idx = 4'd2;
      ".":     r.idx = 4'd3;
      ",":     r.idx = 4'd4;
      "(":     r.idx = 4'd5;
      ")":     r.idx = 4'd6;
      "{":     r.idx = 4'd7;
      "}":     r.idx = 4'd8;
      "[":     r.idx = 4'd9;
      "]":     r.idx = 4'd10;
      default: begin
        r.hit = 1'b0;
        r.idx = 4'd0;
      end
    endcase
    return r;
  endfunction

  // First byte of an operator: : = ! > < + - * / & |
  function automatic lookup_t oper_lookup(input logic [7:0] c);
    lookup_t r;
    r.hit = 1'b1;
    case (c)
      ":":     r.idx = 4'd0;
      "=":     r.idx = 4'd1;
      "!":     r.idx = 4'd2;
      ">":     r.idx = 4'd3;
      "<":     r.idx = 4'd4;
      "+":     r.idx = 4'd5;
      "-":     r.idx = 4'd6;
      "*":     r.idx = 4'd7;
      "/":     r.idx = 4'd8;
      "&":     r.idx = 4'd9;
      "|":     r.idx = 4'd10;
      default: begin
        r.hit = 1'b0;
        r.idx = 4'd0;
      end
    endcase
    return r;
  endfunction

  // Second byte that turns an operator into its two-byte form
  function automatic logic [7:0] oper_second(input logic [3:0] op);
    logic [7:0] s;
    case (op)
      4'd0:    s = ":";
      4'd9:    s = "&";
      4'd10:   s = "|";
      default: s = "=";
    endcase
    return s;
  endfunction

endpackage

/* sv/sbt_if.sv */
// Stream interfaces for source bytes in and tokens out.
interface sbt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface sbt_token_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [23:0] token_offset;
  logic [23:0] token_length;
  logic [1:0]  error_kind;
  logic        last_of_run;

  modport source (
    output valid, output token_kind, output token_offset, output token_length,
    output error_kind, output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input token_offset, input token_length,
    input error_kind, input last_of_run, output ready
  );
endinterface

/* sv/source_byte_tokenizer_unit.sv */
// Top level of the source byte tokenizer: byte register, scanner and result queue.
// The tokenizer takes one source byte per cycle on text_i (a zero byte ends the
// text) and gives tokens on token_o as kind, start offset and length. A token that
// is closed by the following byte is reported with that byte, so one byte gives up
// to two tokens; last_of_run marks the final one. An accepted byte is held in the
// byte register, the scanner then updates its state and writes its tokens
// into an eight-entry result queue, whose head drives token_o. Input runs at
// one byte per cycle while the sink keeps up; the queue drains one token per
// cycle, so text that yields two tokens per byte runs at the sink's rate, and
// text_i is held off while fewer than two free queue slots remain after the
// pending write. After the end-of-input token all offsets start again from zero.
module source_byte_tokenizer_unit
  import sbt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sbt_byte_if.sink    text_i,
  sbt_token_if.source token_o
);

  // Byte register
  logic                   byte_vld_q;
  logic [7:0]             byte_q;

  // Scanner state
  mode_e                  mode_q, mode_d;
  logic [3:0]             pend_q, pend_d;
  logic [OFFSET_BITS-1:0] begin_q, begin_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] len_q, len_d;

  // Result queue
  tok_t                   fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0]     count_q;

  // Scanner outputs
  logic                   a_vld, b_vld;
  tok_t                   a_tok, b_tok;
  logic [1:0]             push_n;
  tok_t                   push0, push1;
  logic                   pop;
  logic                   in_acc;

  // Scan one byte: close the running token, then classify the byte
  always_comb begin
    logic       handled;
    logic [7:0] c;
    logic [3:0] op;
    lookup_t    sl, ol;
    c       = byte_q;
    handled = 1'b0;
    op      = (pend_q < OPER_COUNT) ? pend_q : 4'd0;
    sl      = single_lookup(c);
    ol      = oper_lookup(c);
    mode_d  = mode_q;
    pend_d  = pend_q;
    begin_d = begin_q;
    pos_d   = pos_q;
    len_d   = len_q;
    a_vld   = 1'b0;
    b_vld   = 1'b0;
    a_tok   = '{kind: KIND_EOF, offset: '0, length: '0, err: ERR_NONE, last: 1'b0};
    b_tok   = '{kind: KIND_EOF, offset: '0, length: '0, err: ERR_NONE, last: 1'b0};

    if (byte_vld_q) begin
      // Finish or extend the token in progress
      unique case (mode_q)
        MODE_IDENT, MODE_NUMBER: begin
          if (is_decimal(c) || (mode_q == MODE_IDENT && is_letter(c))) begin
            len_d   = sat_inc(len_q);
            handled = 1'b1;
          end else begin
            a_vld        = 1'b1;
            a_tok.kind   = (mode_q == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
            a_tok.offset = begin_q;
            a_tok.length = len_q;
            mode_d       = MODE_IDLE;
          end
        end
        MODE_OPER: begin
          a_vld        = 1'b1;
          a_tok.offset = begin_q;
          if (c != CH_NUL && c == oper_second(op)) begin
            a_tok.kind   = KIND_OPER_BASE + {1'b0, op, 1'b1};
            a_tok.length = OFFSET_BITS'(2);
            handled      = 1'b1;
          end else begin
            a_tok.kind   = KIND_OPER_BASE + {1'b0, op, 1'b0};
            a_tok.length = OFFSET_BITS'(1);
          end
          mode_d = MODE_IDLE;
          pend_d = 4'd0;
        end
        MODE_STRING: begin
          if (c == CH_NUL) begin
            a_vld     = 1'b1;
            a_tok.kind = KIND_ERROR;
            a_tok.err  = ERR_UNTERMINATED;
            mode_d     = MODE_IDLE;
          end else begin
            len_d = sat_inc(len_q);
            if (c == CH_QUOTE) begin
              a_vld        = 1'b1;
              a_tok.kind   = KIND_STRING;
              a_tok.offset = begin_q;
              a_tok.length = len_d;
              mode_d       = MODE_IDLE;
            end
            handled = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NUL || c == CH_LF || c == CH_CR) begin
            mode_d = MODE_IDLE;
          end else begin
            handled = 1'b1;
          end
        end
        default: mode_d = MODE_IDLE;
      endcase

      // Start a new token from this byte
      pos_d = sat_inc(pos_q);
      if (!handled) begin
        if (c == CH_NUL) begin
          b_vld        = 1'b1;
          b_tok.kind   = KIND_EOF;
          b_tok.offset = pos_q;
          mode_d       = MODE_IDLE;
          pend_d       = 4'd0;
          begin_d      = '0;
          pos_d        = '0;
          len_d        = '0;
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
          // skip whitespace
        end else if (c == CH_HASH) begin
          mode_d = MODE_COMMENT;
        end else if (is_letter(c) || is_decimal(c) || c == CH_QUOTE) begin
          mode_d  = is_letter(c) ? MODE_IDENT : (is_decimal(c) ? MODE_NUMBER : MODE_STRING);
          begin_d = pos_q;
          len_d   = OFFSET_BITS'(1);
        end else if (sl.hit) begin
          b_vld        = 1'b1;
          b_tok.kind   = KIND_SINGLE_BASE + {2'b00, sl.idx};
          b_tok.offset = pos_q;
          b_tok.length = OFFSET_BITS'(1);
        end else if (ol.hit) begin
          mode_d  = MODE_OPER;
          pend_d  = ol.idx;
          begin_d = pos_q;
        end else begin
          b_vld      = 1'b1;
          b_tok.kind = KIND_ERROR;
          b_tok.err  = ERR_UNRECOGNISED;
        end
      end
    end

    // Mark the last token of the run
    a_tok.last = ~b_vld;
    b_tok.last = 1'b1;
  end

  // Pack the tokens for the queue
  always_comb begin
    push0  = a_vld ? a_tok : b_tok;
    push1  = b_tok;
    push_n = {1'b0, a_vld} + {1'b0, b_vld};
  end

  // Take a byte only if the queue keeps two free slots after the pending write
  assign text_i.ready = (count_q + FIFO_CW'(push_n)) <= FIFO_CW'(FIFO_DEPTH - 2);
  assign in_acc       = text_i.valid & text_i.ready;
  assign pop          = token_o.valid & token_o.ready;

  // Byte register and scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
      mode_q     <= MODE_IDLE;
      pend_q     <= 4'd0;
      begin_q    <= '0;
      pos_q      <= '0;
      len_q      <= '0;
    end else begin
      byte_vld_q <= in_acc;
      mode_q     <= mode_d;
      pend_q     <= pend_d;
      begin_q    <= begin_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= text_i.text_byte;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end
  end

  // Queue payload
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= push0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + 1'b1] <= push1;
    end
  end

  // Drive the token beat from the queue head
  assign token_o.valid        = (count_q != '0);
  assign token_o.token_kind   = fifo_q[rd_ptr_q].kind;
  assign token_o.token_offset = fifo_q[rd_ptr_q].offset[23:0];
  assign token_o.token_length = fifo_q[rd_ptr_q].length[23:0];
  assign token_o.error_kind   = fifo_q[rd_ptr_q].err;
  assign token_o.last_of_run  = fifo_q[rd_ptr_q].last;

endmodule

/* sv/sbt_checker.sv */
// Port-level checks for the source byte tokenizer, bound to the top level.
module sbt_checker
  import sbt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        tok_valid_i,
  input logic        tok_ready_i,
  input logic [5:0]  tok_kind_i,
  input logic [23:0] tok_offset_i,
  input logic [23:0] tok_length_i,
  input logic [1:0]  tok_err_i,
  input logic        tok_last_i
);

  // End of input is a zero-length token and always closes its run
  a_eof_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && tok_kind_i == KIND_EOF |->
      tok_length_i == '0 && tok_err_i == ERR_NONE && tok_last_i)
    else $error("eof beat with length, error code or open run");

  // Error beats carry a cause and no position
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && tok_kind_i == KIND_ERROR |->
      tok_offset_i == '0 && tok_length_i == '0 && tok_err_i != ERR_NONE)
    else $error("error beat with offset, length or no cause");

  // An error code appears only on error beats
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && tok_err_i != ERR_NONE |-> tok_kind_i == KIND_ERROR && tok_err_i != 2'd3)
    else $error("error code on a non-error beat");

  // A stalled token beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && !tok_ready_i |=> tok_valid_i && $stable(tok_kind_i) &&
      $stable(tok_offset_i) && $stable(tok_length_i) && $stable(tok_last_i))
    else $error("token beat changed while stalled");

endmodule

bind source_byte_tokenizer_unit sbt_checker u_sbt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tok_valid_i  (token_o.valid),
  .tok_ready_i  (token_o.ready),
  .tok_kind_i   (token_o.token_kind),
  .tok_offset_i (token_o.token_offset),
  .tok_length_i (token_o.token_length),
  .tok_err_i    (token_o.error_kind),
  .tok_last_i   (token_o.last_of_run)
);

/* sim/source_byte_tokenizer_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the source byte tokenizer: directed and random text, token by token.
module source_byte_tokenizer_unit_test;
  import sbt_pkg::*;

  localparam int RANDOM_BYTES  = 1450;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 16;

  logic clk_i = 1'b0;
  logic rst_ni;

  sbt_byte_if  text_if ();
  sbt_token_if token_if ();

  source_byte_tokenizer_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_if),
    .token_o (token_if)
  );

  // Punctuation and operator spellings, in token code order
  logic [7:0] punct_chars [11] = '{";", "?", "%", ".", ",", "(", ")", "{", "}", "[", "]"};
  logic [7:0] oper_head   [11] = '{":", "=", "!", ">", "<", "+", "-", "*", "/", "&", "|"};
  logic [7:0] oper_tail   [11] = '{":", "=", "=", "=", "=", "=", "=", "=", "=", "&", "|"};

  // Scanner state as the tokens predict it
  mode_e                  scan_state;
  logic [3:0]             held_oper;
  logic [OFFSET_BITS-1:0] tok_start;
  logic [OFFSET_BITS-1:0] scan_pos;
  logic [OFFSET_BITS-1:0] run_len;

  tok_t       expected_tokens [$];
  logic [7:0] text_buf [$];
  int         fail_count;
  int         hold_off_left;
  logic       send_idle;
  logic       recv_idle;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic letter_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic blank_byte(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] step_sat(input logic [OFFSET_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic tok_t make_token(input logic [5:0] kind, input logic [OFFSET_BITS-1:0] offset,
                                      input logic [OFFSET_BITS-1:0] length, input logic [1:0] err);
    tok_t t;
    t.kind   = kind;
    t.offset = offset;
    t.length = length;
    t.err    = err;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic void reset_scanner();
    scan_state = MODE_IDLE;
    held_oper  = '0;
    tok_start  = '0;
    scan_pos   = '0;
    run_len    = '0;
  endfunction

  // Work out the tokens that one accepted byte gives and queue them
  function automatic void predict_tokens(input logic [7:0] c);
    tok_t                   found [$];
    logic [OFFSET_BITS-1:0] here;
    logic                   consumed;
    logic                   matched;
    here     = scan_pos;
    consumed = 1'b0;
    matched  = 1'b0;

    // Close or extend the token in progress
    case (scan_state)
      MODE_IDENT: begin
        if (letter_byte(c) || digit_byte(c)) begin
          run_len  = step_sat(run_len);
          consumed = 1'b1;
        end else begin
          found.push_back(make_token(KIND_IDENT, tok_start, run_len, ERR_NONE));
          scan_state = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (digit_byte(c)) begin
          run_len  = step_sat(run_len);
          consumed = 1'b1;
        end else begin
          found.push_back(make_token(KIND_NUMBER, tok_start, run_len, ERR_NONE));
          scan_state = MODE_IDLE;
        end
      end
      MODE_OPER: begin
        if (c != CH_NUL && c == oper_tail[held_oper]) begin
          found.push_back(make_token(KIND_OPER_BASE + 6'({held_oper, 1'b1}), tok_start,
                                     OFFSET_BITS'(2), ERR_NONE));
          consumed = 1'b1;
        end else begin
          found.push_back(make_token(KIND_OPER_BASE + 6'({held_oper, 1'b0}), tok_start,
                                     OFFSET_BITS'(1), ERR_NONE));
        end
        scan_state = MODE_IDLE;
        held_oper  = '0;
      end
      MODE_STRING: begin
        if (c == CH_NUL) begin
          found.push_back(make_token(KIND_ERROR, '0, '0, ERR_UNTERMINATED));
          scan_state = MODE_IDLE;
        end else begin
          run_len = step_sat(run_len);
          if (c == CH_QUOTE) begin
            found.push_back(make_token(KIND_STRING, tok_start, run_len, ERR_NONE));
            scan_state = MODE_IDLE;
          end
          consumed = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NUL || c == CH_LF || c == CH_CR) scan_state = MODE_IDLE;
        else consumed = 1'b1;
      end
      default: scan_state = MODE_IDLE;
    endcase

    if (!consumed && c == CH_NUL) begin
      // End of text: eof at the zero byte, then offsets restart
      found.push_back(make_token(KIND_EOF, here, '0, ERR_NONE));
      reset_scanner();
    end else begin
      // Start whatever the byte opens
      if (!consumed) begin
        if (blank_byte(c)) begin
          // whitespace only moves the offset on
        end else if (c == CH_HASH) begin
          scan_state = MODE_COMMENT;
        end else if (letter_byte(c) || digit_byte(c) || c == CH_QUOTE) begin
          scan_state = letter_byte(c) ? MODE_IDENT : (digit_byte(c) ? MODE_NUMBER : MODE_STRING);
          tok_start  = here;
          run_len    = OFFSET_BITS'(1);
        end else begin
          for (int i = 0; i < 11; i++) begin
            if (!matched && c == punct_chars[i]) begin
              found.push_back(make_token(KIND_SINGLE_BASE + 6'(i), here, OFFSET_BITS'(1),
                                         ERR_NONE));
              matched = 1'b1;
            end
          end
          for (int i = 0; i < 11; i++) begin
            if (!matched && c == oper_head[i]) begin
              scan_state = MODE_OPER;
              held_oper  = 4'(i);
              tok_start  = here;
              matched    = 1'b1;
            end
          end
          if (!matched) found.push_back(make_token(KIND_ERROR, '0, '0, ERR_UNRECOGNISED));
        end
      end
      scan_pos = step_sat(scan_pos);
    end

    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[k]) expected_tokens.push_back(found[k]);
  endfunction

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Compare every token beat with the oldest expectation
  always @(posedge clk_i) begin
    tok_t want;
    if (rst_ni && token_if.valid && token_if.ready) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: token expected none, got kind %0d offset %0d length %0d err %0d",
                 $time, token_if.token_kind, token_if.token_offset, token_if.token_length,
                 token_if.error_kind);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_kind", 24'(want.kind), 24'(token_if.token_kind));
        check_field("token_offset", want.offset, token_if.token_offset);
        check_field("token_length", want.length, token_if.token_length);
        check_field("error_kind", 24'(want.err), 24'(token_if.error_kind));
        check_field("last_of_run", 24'(want.last), 24'(token_if.last_of_run));
      end
    end
  end

  // Token sink: random stall after each beat when recv_idle is set, plus long hold-offs on request
  initial begin
    int sink_wait;
    sink_wait = 0;
    token_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (token_if.valid && token_if.ready) sink_wait = recv_idle ? $urandom_range(0, 5) : 0;
      if (hold_off_left > 0) begin
        hold_off_left--;
        token_if.ready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        token_if.ready <= 1'b0;
      end else begin
        token_if.ready <= 1'b1;
      end
    end
  end

  // Offer one byte, after a random gap when send_idle is set, and hold it until accepted
  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = send_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    text_if.valid     <= 1'b1;
    text_if.text_byte <= value;
    do @(posedge clk_i); while (!text_if.ready);
    predict_tokens(value);
  endtask

  task automatic send_text();
    foreach (text_buf[k]) send_byte(text_buf[k]);
    text_buf.delete();
  endtask

  // Stop offering bytes until every expected token has arrived
  task automatic wait_for_drain();
    text_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_tokens.size() != 0);
  endtask

  function automatic logic [7:0] any_letter();
    int k;
    k = $urandom_range(0, 52);
    if (k < 26) return 8'("a" + k);
    if (k < 52) return 8'("A" + k - 26);
    return "_";
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Any non-zero byte other than the two given
  function automatic logic [7:0] body_byte(input logic [7:0] skip_a, input logic [7:0] skip_b);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == skip_a || c == skip_b);
    return c;
  endfunction

  // Append one lexeme with random content: mostly well-formed, sometimes a raw byte
  function automatic void append_lexeme();
    int n;
    case ($urandom_range(0, 9))
      0, 1: begin
        text_buf.push_back(any_letter());
        n = $urandom_range(0, 7);
        repeat (n) text_buf.push_back($urandom_range(0, 3) == 0 ? any_digit() : any_letter());
      end
      2: begin
        n = $urandom_range(1, 8);
        repeat (n) text_buf.push_back(any_digit());
      end
      3: begin
        text_buf.push_back(CH_QUOTE);
        n = $urandom_range(0, 6);
        repeat (n) text_buf.push_back(body_byte(CH_QUOTE, CH_QUOTE));
        text_buf.push_back(CH_QUOTE);
      end
      4: text_buf.push_back(punct_chars[$urandom_range(0, 10)]);
      5, 6: begin
        n = $urandom_range(0, 10);
        text_buf.push_back(oper_head[n]);
        if ($urandom_range(0, 1) == 1) text_buf.push_back(oper_tail[n]);
      end
      7: begin
        text_buf.push_back(CH_HASH);
        n = $urandom_range(0, 6);
        repeat (n) text_buf.push_back(body_byte(CH_LF, CH_CR));
        text_buf.push_back($urandom_range(0, 1) == 1 ? CH_LF : CH_CR);
      end
      8: begin
        n = $urandom_range(1, 3);
        repeat (n) text_buf.push_back(any_blank());
      end
      default: text_buf.push_back(8'($urandom_range(1, 255)));
    endcase
  endfunction

  // Mostly well-formed texts; some raw noise, open strings and open comments
  function automatic void build_random_text();
    int n;
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(5, 20);
      repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n = $urandom_range(1, 20);
    repeat (n) begin
      append_lexeme();
      if ($urandom_range(0, 2) == 0) text_buf.push_back(any_blank());
    end
    case ($urandom_range(0, 7))
      0: begin
        text_buf.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 3)) text_buf.push_back(body_byte(CH_QUOTE, CH_QUOTE));
      end
      1: begin
        text_buf.push_back(CH_HASH);
        repeat ($urandom_range(0, 3)) text_buf.push_back(body_byte(CH_LF, CH_CR));
      end
      default: ;
    endcase
    if ($urandom_range(0, 9) != 0) text_buf.push_back(CH_NUL);
  endfunction

  // Extremes and the corner cases of token closing, strings and end of text
  task automatic test_directed_text();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    text_buf = '{CH_NUL,
                 "Z", "_", "9", "+", "=", "7", 8'hFF, CH_QUOTE, CH_NUL,
                 CH_HASH, "x", CH_CR, ";", "a", "-", CH_NUL,
                 CH_TAB, "1", "2", CH_NUL,
                 CH_QUOTE, CH_QUOTE, CH_LF, CH_HASH, CH_NUL};
    send_text();
    wait_for_drain();
  endtask

  // Hold the sink off while two-token bytes keep coming, so the input stalls
  task automatic test_full_queue_stall();
    send_idle     = 1'b0;
    recv_idle     = 1'b0;
    hold_off_left = HOLD_CYCLES;
    repeat (20) begin
      text_buf.push_back("k");
      text_buf.push_back("<");
      text_buf.push_back(";");
    end
    text_buf.push_back(CH_NUL);
    send_text();
    wait_for_drain();
  endtask

  task automatic test_random_text();
    int sent;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      build_random_text();
      sent += text_buf.size();
      send_text();
      if ($urandom_range(0, 9) == 0) wait_for_drain();
    end
  endtask

  initial begin
    fail_count    = 0;
    hold_off_left = 0;
    send_idle     = 1'b0;
    recv_idle     = 1'b0;
    reset_scanner();
    rst_ni            <= 1'b0;
    text_if.valid     <= 1'b0;
    text_if.text_byte <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_text();
    test_full_queue_stall();
    test_random_text();

    // Let the last bytes work through before the verdict
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
sv/sbt_pkg.sv
sv/sbt_if.sv
sv/source_byte_tokenizer_unit.sv
sv/sbt_checker.sv
sim/source_byte_tokenizer_unit_test.sv
